// ----- hw/rtl/bst_pkg.sv -----
// shared types and constants for the bencode stream tokenizer
package bst_pkg;

    localparam int DEFAULT_MAX_DEPTH = 32;
    localparam int VAL_W             = 31;
    localparam logic [VAL_W-1:0] VAL_MAX = {VAL_W{1'b1}};

    localparam logic [7:0] CH_I     = 8'h69;
    localparam logic [7:0] CH_L     = 8'h6C;
    localparam logic [7:0] CH_D     = 8'h64;
    localparam logic [7:0] CH_E     = 8'h65;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [3:0] RADIX    = 4'd10;

    typedef enum logic [2:0] {
        EV_INT        = 3'd0,
        EV_STR_LEN    = 3'd1,
        EV_STR_BYTE   = 3'd2,
        EV_LIST_OPEN  = 3'd3,
        EV_DICT_OPEN  = 3'd4,
        EV_LIST_CLOSE = 3'd5,
        EV_DICT_CLOSE = 3'd6,
        EV_ERROR      = 3'd7
    } t_event;

    typedef enum logic [2:0] {
        ERR_NONE      = 3'd0,
        ERR_TRUNCATED = 3'd1,
        ERR_BAD_DIGIT = 3'd2,
        ERR_OVERFLOW  = 3'd3,
        ERR_TOO_DEEP  = 3'd4
    } t_err;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
        logic       restart;
    } t_in_word;

    typedef struct packed {
        logic [2:0]       event_res;
        logic [VAL_W-1:0] value;
        logic [5:0]       depth;
        logic             top_done;
        logic [2:0]       error_code;
    } t_out_word;

    // one open container: 0 list, 1 dict, and offset of its opening byte
    typedef struct packed {
        logic             kind;
        logic [VAL_W-1:0] start;
    } t_stk_entry;

    typedef struct packed {
        logic       clear;
        logic       push;
        logic       pop;
        t_stk_entry entry;
    } t_stk_ctrl;

endpackage

// ----- hw/rtl/bencode_stream_tokenizer_core.sv -----
// top level of the streaming bencode tokenizer
// Takes one buffer byte per clock while the output side takes words, and gives at most
// one token word per byte. An accepted byte is held in the input register and parsed
// from there once the result register can take its token, which is then written into
// the result register. A stalled output fills the input register and then drops ready.
// Open containers live in a stack of MAX_DEPTH entries: the top entry in flops and the
// rest in a memory whose next entry down is always prefetched, so a close moves it
// straight into the top entry. The memory needs no clearing after reset. A restart
// mark on a byte clears the parse state first.
module bencode_stream_tokenizer_core
    import bst_pkg::*;
#(
    parameter int MAX_DEPTH = DEFAULT_MAX_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_word o_out_word
);

    logic       w_hold_valid;
    t_in_word   w_hold_word;
    logic       w_out_free;
    logic       w_adv;
    t_stk_ctrl  w_stk;
    t_stk_entry w_top;

    // parse the held word when the result register can take its token
    assign w_adv = w_hold_valid && w_out_free;

    bst_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_word  (i_in_word),
        .i_take  (w_adv),
        .o_valid (w_hold_valid),
        .o_word  (w_hold_word)
    );

    bst_parse #(
        .MAX_DEPTH (MAX_DEPTH)
    ) u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_adv       (w_adv),
        .i_word      (w_hold_word),
        .o_out_free  (w_out_free),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word),
        .o_stk       (w_stk),
        .i_top       (w_top)
    );

    bst_stack #(
        .MAX_DEPTH (MAX_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_stk),
        .o_top   (w_top)
    );

endmodule

// ----- hw/rtl/bst_in_reg.sv -----
// input register that holds one word in front of the parser
module bst_in_reg
    import bst_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_in_word i_word,
    input  logic     i_take,
    output logic     o_valid,
    output t_in_word o_word
);

    logic     r_valid;
    t_in_word r_word;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_word  = r_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_word <= i_word;
        end
    end

endmodule

// ----- hw/rtl/bst_stack.sv -----
// container stack: top entry in flops, deeper entries in a memory with prefetch
module bst_stack
    import bst_pkg::*;
#(
    parameter int MAX_DEPTH = DEFAULT_MAX_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_stk_ctrl  i_ctrl,
    output t_stk_entry o_top
);

    localparam int LVL_W = $clog2(MAX_DEPTH + 1);
    localparam int AW    = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

    t_stk_entry       mem [MAX_DEPTH];
    t_stk_entry       r_top;
    t_stk_entry       r_below;
    logic [LVL_W-1:0] r_lvl;
    logic [LVL_W-1:0] n_lvl;
    logic [LVL_W-1:0] lvl_e;
    logic [LVL_W-1:0] lvl_dec;
    logic [LVL_W-1:0] rd_lvl;
    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    logic [AW-1:0]    rd_addr;

    assign lvl_e   = i_ctrl.clear ? '0 : r_lvl;
    assign lvl_dec = lvl_e - LVL_W'(1);
    assign wr_en   = i_ctrl.push && (lvl_e != '0);
    assign wr_addr = lvl_dec[AW-1:0];

    always_comb begin
        n_lvl = lvl_e;
        if (i_ctrl.push) begin
            n_lvl = lvl_e + LVL_W'(1);
        end else if (i_ctrl.pop) begin
            n_lvl = lvl_dec;
        end
    end

    // entry just below the next top
    assign rd_lvl  = n_lvl - LVL_W'(2);
    assign rd_addr = rd_lvl[AW-1:0];
    assign o_top   = r_top;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lvl <= '0;
        end else begin
            r_lvl <= n_lvl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.push) begin
            r_top <= i_ctrl.entry;
        end else if (i_ctrl.pop) begin
            r_top <= r_below;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= r_top;
        end
        if (wr_en && (wr_addr == rd_addr)) begin
            r_below <= r_top;
        end else begin
            r_below <= mem[rd_addr];
        end
    end

endmodule

// ----- hw/rtl/bst_parse.sv -----
// parse state, per-byte next-state logic and result register
module bst_parse
    import bst_pkg::*;
#(
    parameter int MAX_DEPTH = DEFAULT_MAX_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_adv,
    input  t_in_word   i_word,
    output logic       o_out_free,
    input  logic       i_out_ready,
    output logic       o_out_valid,
    output t_out_word  o_out_word,
    output t_stk_ctrl  o_stk,
    input  t_stk_entry i_top
);

    localparam int LVL_W = $clog2(MAX_DEPTH + 1);

    typedef enum logic [6:0] {
        MODE_ITEM      = 7'b0000001,
        MODE_INT_FIRST = 7'b0000010,
        MODE_INT_MORE  = 7'b0000100,
        MODE_STR_LEN   = 7'b0001000,
        MODE_STR_BODY  = 7'b0010000,
        MODE_DONE      = 7'b0100000,
        MODE_ERROR     = 7'b1000000
    } t_mode;

    t_mode            r_mode, n_mode, mode_e;
    logic [VAL_W-1:0] r_acc, n_acc, acc_e;
    logic [VAL_W-1:0] r_rem, n_rem, rem_e;
    logic [VAL_W-1:0] r_pos, n_pos, pos_e;
    logic [LVL_W-1:0] r_level, n_level, lvl_e;
    logic             r_out_valid;
    t_out_word        r_out_word;

    logic [7:0]       b;
    logic             is_digit;
    logic [3:0]       digit;
    logic [VAL_W+3:0] mac;
    logic             ovf;
    logic             live;
    logic             have;
    logic             tdone;
    logic             push, pop;
    t_event           ev;
    t_err             err;
    logic [VAL_W-1:0] val;
    t_out_word        w_out;

    assign b        = i_word.data_byte;
    assign is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
    assign digit    = 4'(b - CH_ZERO);

    assign mode_e = i_word.restart ? MODE_ITEM : r_mode;
    assign acc_e  = i_word.restart ? '0 : r_acc;
    assign rem_e  = i_word.restart ? '0 : r_rem;
    assign pos_e  = i_word.restart ? '0 : r_pos;
    assign lvl_e  = i_word.restart ? '0 : r_level;
    assign n_pos  = (pos_e != VAL_MAX) ? pos_e + VAL_W'(1) : pos_e;

    assign mac  = (VAL_W+4)'(acc_e) * (VAL_W+4)'(RADIX) + (VAL_W+4)'(digit);
    assign ovf  = mac > (VAL_W+4)'(VAL_MAX);
    assign live = (mode_e != MODE_DONE) && (mode_e != MODE_ERROR);

    always_comb begin
        n_mode  = mode_e;
        n_acc   = acc_e;
        n_rem   = rem_e;
        n_level = lvl_e;
        ev      = EV_INT;
        val     = '0;
        tdone   = 1'b0;
        err     = ERR_NONE;
        have    = 1'b0;
        push    = 1'b0;
        pop     = 1'b0;
        unique case (mode_e) inside
            MODE_ITEM: begin
                if (b == CH_I) begin
                    n_mode = MODE_INT_FIRST;
                    n_acc  = '0;
                end else if (b == CH_L || b == CH_D) begin
                    if (lvl_e >= LVL_W'(MAX_DEPTH)) begin
                        err = ERR_TOO_DEEP;
                    end else begin
                        push    = 1'b1;
                        n_level = lvl_e + LVL_W'(1);
                        ev      = (b == CH_D) ? EV_DICT_OPEN : EV_LIST_OPEN;
                        have    = 1'b1;
                    end
                end else if (b == CH_E && lvl_e != '0) begin
                    pop     = 1'b1;
                    n_level = lvl_e - LVL_W'(1);
                    have    = 1'b1;
                    if (i_top.kind) begin
                        ev  = EV_DICT_CLOSE;
                        val = pos_e - i_top.start + VAL_W'(1);
                    end else begin
                        ev = EV_LIST_CLOSE;
                    end
                    if (n_level == '0) begin
                        n_mode = MODE_DONE;
                        tdone  = 1'b1;
                    end
                end else if (is_digit) begin
                    n_mode = MODE_STR_LEN;
                    n_acc  = VAL_W'(digit);
                end else begin
                    err = ERR_BAD_DIGIT;
                end
            end
            MODE_INT_FIRST, MODE_INT_MORE: begin
                if (is_digit) begin
                    if (ovf) begin
                        err = ERR_OVERFLOW;
                    end else begin
                        n_acc  = mac[VAL_W-1:0];
                        n_mode = MODE_INT_MORE;
                    end
                end else if (b == CH_E && mode_e == MODE_INT_MORE) begin
                    ev   = EV_INT;
                    val  = acc_e;
                    have = 1'b1;
                    if (lvl_e == '0) begin
                        n_mode = MODE_DONE;
                        tdone  = 1'b1;
                    end else begin
                        n_mode = MODE_ITEM;
                    end
                end else begin
                    err = ERR_BAD_DIGIT;
                end
            end
            MODE_STR_LEN: begin
                if (is_digit) begin
                    if (ovf) begin
                        err = ERR_OVERFLOW;
                    end else begin
                        n_acc = mac[VAL_W-1:0];
                    end
                end else if (b == CH_COLON) begin
                    ev    = EV_STR_LEN;
                    val   = acc_e;
                    have  = 1'b1;
                    n_rem = acc_e;
                    if (acc_e != '0) begin
                        n_mode = MODE_STR_BODY;
                    end else if (lvl_e == '0) begin
                        n_mode = MODE_DONE;
                        tdone  = 1'b1;
                    end else begin
                        n_mode = MODE_ITEM;
                    end
                end else begin
                    err = ERR_BAD_DIGIT;
                end
            end
            MODE_STR_BODY: begin
                ev    = EV_STR_BYTE;
                val   = VAL_W'(b);
                have  = 1'b1;
                n_rem = (rem_e != '0) ? rem_e - VAL_W'(1) : rem_e;
                if (n_rem == '0) begin
                    if (lvl_e == '0) begin
                        n_mode = MODE_DONE;
                        tdone  = 1'b1;
                    end else begin
                        n_mode = MODE_ITEM;
                    end
                end
            end
            default: begin
                // done or error: byte ignored
            end
        endcase

        if (live && err == ERR_NONE && i_word.last_byte && n_mode != MODE_DONE) begin
            err = ERR_TRUNCATED;
        end
        if (err != ERR_NONE) begin
            n_mode = MODE_ERROR;
            ev     = EV_ERROR;
            val    = '0;
            tdone  = 1'b0;
            have   = 1'b1;
        end
    end

    assign w_out.event_res  = ev;
    assign w_out.value      = val;
    assign w_out.depth      = 6'(n_level);
    assign w_out.top_done   = tdone;
    assign w_out.error_code = err;

    assign o_stk.clear = i_adv && i_word.restart;
    assign o_stk.push  = i_adv && push;
    assign o_stk.pop   = i_adv && pop;
    assign o_stk.entry = '{kind: (b == CH_D), start: pos_e};

    assign o_out_free  = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_ITEM;
            r_acc   <= '0;
            r_rem   <= '0;
            r_pos   <= '0;
            r_level <= '0;
        end else if (i_adv) begin
            r_mode  <= n_mode;
            r_acc   <= n_acc;
            r_rem   <= n_rem;
            r_pos   <= n_pos;
            r_level <= n_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_out_free) begin
            r_out_valid <= i_adv && have;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_out_free) begin
            r_out_word <= w_out;
        end
    end

`ifndef SYNTHESIS
    a_err_fields : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_word.event_res == EV_ERROR |->
            r_out_word.error_code != ERR_NONE && r_out_word.value == '0
            && !r_out_word.top_done)
        else $error("error word with bad fields");

    a_ok_no_code : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_word.event_res != EV_ERROR |->
            r_out_word.error_code == ERR_NONE)
        else $error("error code on non-error word");

    a_quiet_after_end : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_adv && !i_word.restart && (r_mode == MODE_DONE || r_mode == MODE_ERROR)
            |-> !have)
        else $error("result after finished or failed buffer");

    a_level_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_level <= LVL_W'(MAX_DEPTH))
        else $error("nesting level beyond limit");

    a_pop_nonempty : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stk.pop |-> lvl_e != '0 && !o_stk.push)
        else $error("pop of empty stack");
`endif

endmodule
